/* sv/gpd_pkg.sv */
// Shared constants for the Gaussian pyramid downsample core.
`default_nettype none

package gpd_pkg;

  // Pixel and sum widths
  localparam int PIX_W    = 8;
  localparam int COLSUM_W = 12;  // 16 * 255 fits in 12 bits
  localparam int SUM_W    = 16;  // 256 * 255 fits in 16 bits
  localparam int NIN      = 3;   // channels carried on the input ports

  // Geometry
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CHANNELS_DEF  = 3;
  localparam int WCFG_W        = 12;
  localparam int HCFG_W        = 13;
  localparam int ROW_W         = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 5;

  localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(480);

  // Config port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Binomial taps 1,4,6,4,1 (symmetric)
  localparam logic [4:0][2:0] TAP = {3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

endpackage

`default_nettype wire

/* sv/gpd_line_mem.sv */
// Line buffer memory: one read and one write port, registered read data.
`default_nettype none

module gpd_line_mem #(
  parameter int DEPTH = gpd_pkg::MAX_WIDTH_DEF,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* sv/gpd_lane.sv */
// One channel lane: 5x5 binomial filter split into column and row passes.
`default_nettype none

module gpd_lane (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic [4:0][4:0][gpd_pkg::PIX_W-1:0]   win_i,  // [row][col]
  output logic      [gpd_pkg::SUM_W-1:0]             sum_o
);

  logic [4:0][gpd_pkg::COLSUM_W-1:0] colsum_d, colsum_q;

  // vertical pass per column
  always_comb begin
    logic [gpd_pkg::COLSUM_W-1:0] acc;
    for (int c = 0; c < 5; c++) begin
      acc = '0;
      for (int r = 0; r < 5; r++) begin
        acc = acc + gpd_pkg::COLSUM_W'(gpd_pkg::TAP[r])
                  * gpd_pkg::COLSUM_W'(win_i[r][c]);
      end
      colsum_d[c] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      colsum_q <= colsum_d;
    end
  end

  // horizontal pass
  always_comb begin
    logic [gpd_pkg::SUM_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < 5; c++) begin
      acc = acc + gpd_pkg::SUM_W'(gpd_pkg::TAP[c]) * gpd_pkg::SUM_W'(colsum_q[c]);
    end
    sum_o = acc;
  end

endmodule

`default_nettype wire

/* sv/gaussian_pyramid_downsample_core.sv */
// Top level: Gaussian pyramid reduce (5x5 binomial, 2:1 in each direction).
// Path: line memory read register, window, column sums, then output register.
// Throughput: one pixel per cycle unless the output blocks, set by the line memory
//   read-modify-write (one read and one write per pixel, at different columns).
// Reset: counters to zero, width/height to 640/480, pipeline and output emptied.
//   No clearing pass; line memory and window contents are undefined until written.
`default_nettype none

module gaussian_pyramid_downsample_core #(
  parameter int MAX_WIDTH = gpd_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = gpd_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // pixel input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [gpd_pkg::PIX_W-1:0]         pixel_ch0_i,
  input  wire logic [gpd_pkg::PIX_W-1:0]         pixel_ch1_i,
  input  wire logic [gpd_pkg::PIX_W-1:0]         pixel_ch2_i,
  // result output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [gpd_pkg::SUM_W-1:0]         out_ch0_o,
  output logic      [gpd_pkg::SUM_W-1:0]         out_ch1_o,
  output logic      [gpd_pkg::SUM_W-1:0]         out_ch2_o,
  output logic                                   out_last_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [gpd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [gpd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int PW    = gpd_pkg::PIX_W;
  localparam int NIN   = gpd_pkg::NIN;
  localparam int LANES = (CHANNELS < NIN) ? CHANNELS : NIN;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WC    = 14;              // holds any width up to 8192
  localparam int HW    = gpd_pkg::HCFG_W;
  localparam int RW    = gpd_pkg::ROW_W;

  typedef logic [LANES-1:0][PW-1:0] px_t;         // one pixel, all lanes
  typedef logic [3:0][LANES-1:0][PW-1:0] word_t;  // [0] = newest stored row

  // pipeline tag: travels with each beat
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } tag_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective geometry
  // ---------------------------------------------------------------------------
  logic [gpd_pkg::WCFG_W-1:0] width_q;
  logic [gpd_pkg::HCFG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gpd_pkg::WIDTH_RST;
      height_q <= gpd_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gpd_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[gpd_pkg::WCFG_W-1:0];
        gpd_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata_i[gpd_pkg::HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp width to 5..MAX_WIDTH and height to 5..4096, keep last index
  logic [WC-1:0] w_eff, w_last;
  logic [HW-1:0] h_eff, h_last;

  always_comb begin
    logic [WC-1:0] w_ext;
    w_ext = WC'(width_q);
    if (w_ext < WC'(gpd_pkg::MIN_DIM)) begin
      w_eff = WC'(gpd_pkg::MIN_DIM);
    end else if (w_ext > WC'(MAX_WIDTH)) begin
      w_eff = WC'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_q < HW'(gpd_pkg::MIN_DIM)) begin
      h_eff = HW'(gpd_pkg::MIN_DIM);
    end else if (height_q > HW'(gpd_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(gpd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    w_last = w_eff - WC'(1);
    h_last = h_eff - HW'(1);
  end

  // ---------------------------------------------------------------------------
  // Flow control: only a result blocked at the output stalls the pipe
  // ---------------------------------------------------------------------------
  tag_t s1_tag_q, s2_tag_q, s3_tag_q;
  logic out_valid_q;
  logic advance, accept;

  assign advance    = !(s3_tag_q.valid && s3_tag_q.emit && out_valid_q && !out_ready_i);
  assign accept     = in_valid_i && advance;
  assign in_ready_o = advance;

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WC-1:0] col_ext;
  logic [HW-1:0] row_ext;
  logic          emit_now, last_now;

  assign col_ext = WC'(col_q);
  assign row_ext = HW'(row_q);

  // bottom-right of window on even row/col >= 4, inside the frame
  assign emit_now = (row_ext >= HW'(4)) && (col_ext >= WC'(4))
                 && !row_q[0] && !col_q[0]
                 && (row_ext <= h_last) && (col_ext <= w_last);
  assign last_now = (row_ext == {h_last[HW-1:1], 1'b0})
                 && (col_ext == {w_last[WC-1:1], 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_ext >= w_last) begin
        col_q <= '0;
        if (row_ext >= h_last) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory read; the column shifts down on write-back
  // ---------------------------------------------------------------------------
  logic [NIN-1:0][PW-1:0] px_in;
  px_t                    px_lanes;
  px_t                    s1_px_q;
  logic [AW-1:0]          s1_addr_q;
  word_t                  rd_word, wr_word;
  logic                   mem_wr_en;

  assign px_in = {pixel_ch2_i, pixel_ch1_i, pixel_ch0_i};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      px_lanes[l] = px_in[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else if (advance) begin
      s1_tag_q <= '{valid: accept, emit: accept && emit_now, last: last_now};
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= px_lanes;
      s1_addr_q <= col_q;
    end
  end

  assign mem_wr_en = s1_tag_q.valid && advance;
  assign wr_word   = {rd_word[2], rd_word[1], rd_word[0], s1_px_q};

  gpd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .WIDTH ($bits(word_t))
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_word)
  );

  // ---------------------------------------------------------------------------
  // 5x5 window: [row][col], row 4 is the current line, col 4 the newest pixel
  // ---------------------------------------------------------------------------
  logic [4:0][4:0][LANES-1:0][PW-1:0] win_q, win_d;
  logic [4:0][LANES-1:0][PW-1:0]      fresh;

  always_comb begin
    fresh[0] = rd_word[3];
    fresh[1] = rd_word[2];
    fresh[2] = rd_word[1];
    fresh[3] = rd_word[0];
    fresh[4] = s1_px_q;
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
      win_d[r][4] = fresh[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      win_q <= win_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-3: one filter lane per channel
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][gpd_pkg::SUM_W-1:0] lane_sum;
  logic                                 lane_en;

  assign lane_en = s2_tag_q.valid && s2_tag_q.emit && advance;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [4:0][4:0][PW-1:0] lane_win;

    always_comb begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          lane_win[r][c] = win_q[r][c][l];
        end
      end
    end

    gpd_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .win_i (lane_win),
      .sum_o (lane_sum[l])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge: output register collects lane sums and the last flag
  // ---------------------------------------------------------------------------
  logic [NIN-1:0][gpd_pkg::SUM_W-1:0] out_ch_d, out_ch_q;
  logic                               out_last_q;
  logic                               out_load;

  assign out_load = advance && s3_tag_q.valid && s3_tag_q.emit;

  always_comb begin
    for (int ch = 0; ch < NIN; ch++) begin
      out_ch_d[ch] = '0;  // channels beyond CHANNELS read zero
    end
    for (int l = 0; l < LANES; l++) begin
      out_ch_d[l] = lane_sum[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q   <= out_ch_d;
      out_last_q <= s3_tag_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch0_o   = out_ch_q[0];
  assign out_ch1_o   = out_ch_q[1];
  assign out_ch2_o   = out_ch_q[2];
  assign out_last_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input is refused only while a result is stuck at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // the line memory never reads a column that is being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_wr_en) |-> (col_q != s1_addr_q))
    else $error("line memory read/write collision");

  // a blocked result stays parked at the last stage
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_tag_q.valid && s3_tag_q.emit && !advance) |=> (s3_tag_q.valid && s3_tag_q.emit))
    else $error("blocked result dropped");

endmodule

`default_nettype wire

/* tb/sv/tb_gaussian_pyramid_downsample_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Gaussian pyramid reduce core.
module tb_gaussian_pyramid_downsample_core;

  localparam int PIX_W       = gpd_pkg::PIX_W;
  localparam int SUM_W       = gpd_pkg::SUM_W;
  localparam int WCFG_W      = gpd_pkg::WCFG_W;
  localparam int HCFG_W      = gpd_pkg::HCFG_W;
  localparam int CFG_ADDR_W  = gpd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = gpd_pkg::CFG_DATA_W;
  localparam int MIN_DIM     = gpd_pkg::MIN_DIM;
  localparam int MAX_H       = gpd_pkg::MAX_HEIGHT;
  localparam int MAX_W       = gpd_pkg::MAX_WIDTH_DEF;
  localparam int NCH         = gpd_pkg::CHANNELS_DEF;
  localparam int LATENCY     = 3;          // accept-to-result
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;        // long output stall for the back-pressure test
  localparam int MAX_REPORTS = 10;

  // 1,4,6,4,1 is symmetric, so the index order does not matter
  localparam logic [4:0][3:0] BINOM = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

  typedef logic [PIX_W-1:0] sample_t;

  typedef struct packed {
    logic [SUM_W-1:0] ch0;
    logic [SUM_W-1:0] ch1;
    logic [SUM_W-1:0] ch2;
    logic             last;
  } blur_t;

  // how the channel samples of a frame are chosen
  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_ZERO, FILL_FULL} fill_e;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sample_t               px_ch0    = '0;
  sample_t               px_ch1    = '0;
  sample_t               px_ch2    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SUM_W-1:0]      res_ch0, res_ch1, res_ch2;
  logic                  res_last;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = gpd_pkg::REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gaussian_pyramid_downsample_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pixel_ch0_i (px_ch0),
    .pixel_ch1_i (px_ch1),
    .pixel_ch2_i (px_ch2),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_ch0_o   (res_ch0),
    .out_ch1_o   (res_ch1),
    .out_ch2_o   (res_ch2),
    .out_last_o  (res_last),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  initial forever #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioral reduce: own copy of geometry, line rows, window and raster position
  // ---------------------------------------------------------------------------
  logic [WCFG_W-1:0] geom_width;
  logic [HCFG_W-1:0] geom_height;
  sample_t           line_mem [4][MAX_W][NCH];   // [0] is the most recent row
  sample_t           win [5][5][NCH];            // [row][col], row 4 / col 4 newest
  int unsigned       col_pos;
  int unsigned       row_pos;
  blur_t             expected_blurs [$];
  int                mismatches = 0;

  // idle percentages of the two sides, and the long-stall request toggle
  int   src_gap_pct    = 0;
  int   sink_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_ack       = 1'b0;
  int   hold_left      = 0;
  int unsigned cycles  = 0;

  // registers hold raw words; the core clamps them to the legal frame range
  function automatic int unsigned eff_width();
    int unsigned w;
    w = geom_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = geom_height;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // One accepted pixel: update line rows and window, queue a blur if this
  // position is an even interior one, then advance the raster position.
  task automatic blur_and_decimate(input sample_t s0, input sample_t s1,
                                   input sample_t s2);
    int unsigned w, h, cidx;
    int unsigned sums [NCH];
    sample_t     px [NCH];
    sample_t     fresh [5][NCH];
    blur_t       b;
    w = eff_width();
    h = eff_height();
    cidx = (col_pos < MAX_W) ? col_pos : MAX_W - 1;
    px[0] = s0;
    px[1] = s1;
    px[2] = s2;
    // new window column: oldest row on top, current pixel at the bottom
    for (int ch = 0; ch < NCH; ch++) begin
      fresh[0][ch] = line_mem[3][cidx][ch];
      fresh[1][ch] = line_mem[2][cidx][ch];
      fresh[2][ch] = line_mem[1][cidx][ch];
      fresh[3][ch] = line_mem[0][cidx][ch];
      fresh[4][ch] = px[ch];
      line_mem[3][cidx][ch] = line_mem[2][cidx][ch];
      line_mem[2][cidx][ch] = line_mem[1][cidx][ch];
      line_mem[1][cidx][ch] = line_mem[0][cidx][ch];
      line_mem[0][cidx][ch] = px[ch];
    end
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++)
        for (int ch = 0; ch < NCH; ch++) win[r][c][ch] = win[r][c+1][ch];
      for (int ch = 0; ch < NCH; ch++) win[r][4][ch] = fresh[r][ch];
    end
    if (row_pos >= 4 && col_pos >= 4 && row_pos % 2 == 0 && col_pos % 2 == 0
        && row_pos < h && col_pos < w) begin
      for (int ch = 0; ch < NCH; ch++) begin
        sums[ch] = 0;
        for (int r = 0; r < 5; r++)
          for (int c = 0; c < 5; c++)
            sums[ch] += 32'(BINOM[r]) * 32'(BINOM[c]) * 32'(win[r][c][ch]);
      end
      b.ch0  = SUM_W'(sums[0]);
      b.ch1  = SUM_W'(sums[1]);
      b.ch2  = SUM_W'(sums[2]);
      // last kept pixel sits at the last even row and column of the frame
      b.last = (row_pos == ((h - 1) & ~32'd1)) && (col_pos == ((w - 1) & ~32'd1));
      expected_blurs = {expected_blurs, b};
    end
    // counters at or past the last position wrap (matters after a mid-frame resize)
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t pick_sample(input fill_e fill);
    case (fill)
      FILL_ZERO:    return '0;
      FILL_FULL:    return {PIX_W{1'b1}};
      FILL_EXTREME: return $urandom_range(1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      default:      return sample_t'($urandom);
    endcase
  endfunction

  // Called right after the clock rises; returns once the core has taken the beat.
  task automatic send_pixel(input fill_e fill);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    px_ch0   <= pick_sample(fill);
    px_ch1   <= pick_sample(fill);
    px_ch2   <= pick_sample(fill);
    do @(posedge clk); while (!in_ready);
    blur_and_decimate(px_ch0, px_ch1, px_ch2);
  endtask

  // At least one pixel, then on until the raster position is back at the origin.
  task automatic send_to_frame_end(input fill_e fill);
    do send_pixel(fill); while (row_pos != 0 || col_pos != 0);
  endtask

  // Drop valid, let every expected blur come out, then cover pixels still in
  // flight that make no result before the registers may be touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_blurs.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Width then height on consecutive edges; only called while settled.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_word,
                              input logic [CFG_DATA_W-1:0] h_word);
    cfg_we    <= 1'b1;
    cfg_addr  <= gpd_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= w_word;
    @(posedge clk);
    geom_width = w_word[WCFG_W-1:0];
    cfg_addr  <= gpd_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= h_word;
    @(posedge clk);
    geom_height = h_word[HCFG_W-1:0];
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idle(input int src_pct, input int sink_pct);
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 640x480: one full row plus five pixels leave the counters
  // at row 1, column 5. A shrink below the minimum (clamps to 5x5) makes the
  // column wrap on the next pixel, and the frame runs out from row 2.
  task automatic test_reset_geometry();
    repeat (640 + 5) send_pixel(FILL_RANDOM);
    settle();
    set_geometry(13'd3, 13'd0);
    send_to_frame_end(FILL_RANDOM);
  endtask

  // Smallest legal frame with saturated, zero and 0/255 mixed samples.
  task automatic test_extreme_pixels();
    settle();
    set_geometry(13'd5, 13'd5);
    send_to_frame_end(FILL_FULL);
    send_to_frame_end(FILL_ZERO);
    send_to_frame_end(FILL_EXTREME);
  endtask

  // Register words beyond the legal range. All-ones width (bit 12 is not part
  // of the width register, 4095 clamps to 2048) with a too-small height runs a
  // long partial row. Minimum width with all-ones height (clamps to 4096 rows)
  // then wraps the column at once and passes nine rows with no frame end.
  // A 5x4 frame (height clamps to 5) closes the test.
  task automatic test_geometry_clamp();
    settle();
    set_geometry(13'h1FFF, 13'd4);
    repeat (40) send_pixel(FILL_RANDOM);
    settle();
    set_geometry(13'd5, 13'h1FFF);
    repeat (41) send_pixel(FILL_RANDOM);
    settle();
    set_geometry(13'd5, 13'd4);
    send_to_frame_end(FILL_RANDOM);
    send_to_frame_end(FILL_RANDOM);
  endtask

  // Height cut mid-frame below the current row: the rest of that row makes no
  // blurs, the frame then restarts at the new height.
  task automatic test_height_shrink();
    settle();
    set_geometry(13'd7, 13'd8);
    repeat (6 * 7 + 3) send_pixel(FILL_RANDOM);
    settle();
    set_geometry(13'd7, 13'd6);
    send_to_frame_end(FILL_RANDOM);
    send_to_frame_end(FILL_RANDOM);
  endtask

  // Whole frames of random geometry, mostly small; some back to back with no
  // reconfiguration so frame boundaries pass under traffic.
  task automatic test_random_frames(input int target);
    int          sent;
    int unsigned w, h;
    fill_e       fill;
    sent = 0;
    while (sent < target) begin
      if (sent == 0 || $urandom_range(3) != 0) begin
        settle();
        case ($urandom_range(7))
          0:       w = $urandom_range(4);
          1:       w = $urandom_range(24, 17);
          default: w = $urandom_range(12, 5);
        endcase
        case ($urandom_range(7))
          0:       h = $urandom_range(4);
          default: h = $urandom_range(10, 5);
        endcase
        // bit 12 of the width word is outside the register and must be dropped
        set_geometry({1'($urandom_range(1)), WCFG_W'(w)}, HCFG_W'(h));
      end
      fill = ($urandom_range(5) == 0) ? FILL_EXTREME : FILL_RANDOM;
      sent += eff_width() * eff_height();
      send_to_frame_end(fill);
    end
  endtask

  // Receiver stalls for a long stretch while pixels keep coming, so the core
  // backs up all the way to its input.
  task automatic test_output_backpressure();
    settle();
    set_geometry(13'd12, 13'd8);
    hold_req <= ~hold_req;
    send_to_frame_end(FILL_RANDOM);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each beat against the oldest expected blur
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    blur_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {res_ch0, res_ch1, res_ch2, res_last};
      if (expected_blurs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat ch0=%0d ch1=%0d ch2=%0d last=%0b",
                   $time, got.ch0, got.ch1, got.ch2, got.last);
      end else begin
        want = expected_blurs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp %0d %0d %0d last=%0b, got %0d %0d %0d last=%0b",
                     $time, want.ch0, want.ch1, want.ch2, want.last,
                     got.ch0, got.ch1, got.ch2, got.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("gaussian_pyramid_downsample_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    geom_width  = gpd_pkg::WIDTH_RST;
    geom_height = gpd_pkg::HEIGHT_RST;
    col_pos     = 0;
    row_pos     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles a third of the time, receiver most of the time
    set_idle(32, 61);
    test_reset_geometry();
    test_extreme_pixels();

    // roles swapped
    settle();
    set_idle(61, 32);
    test_geometry_clamp();
    test_height_shrink();
    test_random_frames(40);

    // full rate both sides, with the long receiver hold-off first
    settle();
    set_idle(0, 0);
    test_output_backpressure();
    test_random_frames(40);

    settle();
    if (mismatches == 0 && expected_blurs.size() == 0)
      $display("gaussian_pyramid_downsample_core verification clean");
    else
      $display("gaussian_pyramid_downsample_core verification failed");
    $finish;
  end

endmodule
